// ----- hw/rtl/orthonormalize_3x3_frame_top_macros.svh -----
// assertion helpers for the frame block, clocked on clk and quiet in reset
`ifndef ORTHONORMALIZE_3X3_FRAME_TOP_MACROS_SVH
`define ORTHONORMALIZE_3X3_FRAME_TOP_MACROS_SVH

// consequent must hold in the same cycle as the antecedent
`define ORTHO_ASSERT_NOW(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent must hold in the cycle after the antecedent
`define ORTHO_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/ortho_pkg.sv -----
`timescale 1ns / 1ps

package ortho_pkg;

    // input components, signed Q3.12
    localparam int InW = 16;
    // unit vector components, signed Q1.14
    localparam int UnitW = 16;
    localparam int UnitFrac = 14;
    localparam int UnitOne = 1 << UnitFrac;
    // quotient x^2 * 2^30 / s, one extra bit for the leading step
    localparam int QuotW = 2 * UnitFrac + 3;

    // component widths fed to the three normalizers
    localparam int NormAW = InW;
    localparam int NormEW = 26;
    localparam int NormXW = 31;

    // projection removal
    localparam int ProjShift = 20;
    localparam int BScale = 8;

    typedef logic signed [InW-1:0] comp_t;
    typedef logic signed [UnitW-1:0] unit_t;

endpackage

// ----- hw/rtl/ortho_in_if.sv -----
`timescale 1ns / 1ps

interface ortho_in_if;
    logic valid;
    logic ready;
    ortho_pkg::comp_t a_x;
    ortho_pkg::comp_t a_y;
    ortho_pkg::comp_t a_z;
    ortho_pkg::comp_t b_x;
    ortho_pkg::comp_t b_y;
    ortho_pkg::comp_t b_z;
    ortho_pkg::comp_t c_x;
    ortho_pkg::comp_t c_y;
    ortho_pkg::comp_t c_z;

    modport source (
        output valid, a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z,
        input  ready
    );
    modport sink (
        input  valid, a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z,
        output ready
    );
endinterface

// ----- hw/rtl/ortho_out_if.sv -----
`timescale 1ns / 1ps

interface ortho_out_if;
    logic valid;
    logic ready;
    ortho_pkg::unit_t u_x;
    ortho_pkg::unit_t u_y;
    ortho_pkg::unit_t u_z;
    ortho_pkg::unit_t v_x;
    ortho_pkg::unit_t v_y;
    ortho_pkg::unit_t v_z;
    ortho_pkg::unit_t w_x;
    ortho_pkg::unit_t w_y;
    ortho_pkg::unit_t w_z;
    logic degenerate;

    modport source (
        output valid, u_x, u_y, u_z, v_x, v_y, v_z, w_x, w_y, w_z, degenerate,
        input  ready
    );
    modport sink (
        input  valid, u_x, u_y, u_z, v_x, v_y, v_z, w_x, w_y, w_z, degenerate,
        output ready
    );
endinterface

// ----- hw/rtl/orthonormalize_3x3_frame_top.sv -----
`timescale 1ns / 1ps

// Gram-Schmidt frame builder: takes three Q3.12 vectors a, b, c and returns the
// orthonormal frame u, v, w in Q1.14, rounded to nearest with halves away from
// zero; c only picks the handedness of w. A frame with a zero first vector, a
// zero residual of b, or a c orthogonal to u x v comes out with degenerate set
// and all nine components zero. The block is a fixed pipeline that takes one
// frame every clock while the skid word is free, and stalls while it is held.
// Most of its depth lies in the three normalizers, each a 31-stage restoring
// divider followed by a 16-stage square root, chained because v needs u and
// w needs v. An output register plus one skid word decouple the sides, so
// input ready depends only on whether the skid word is occupied.
module orthonormalize_3x3_frame_top (
    input  logic        clk,
    input  logic        rst_n,
    ortho_in_if.sink    in_ch,
    ortho_out_if.source out_ch
);

`include "orthonormalize_3x3_frame_top_macros.svh"

    localparam int InW   = ortho_pkg::InW;
    localparam int UnitW = ortho_pkg::UnitW;
    localparam int EW    = ortho_pkg::NormEW;
    localparam int XW    = ortho_pkg::NormXW;
    localparam int PrW   = UnitW + InW;
    localparam int PdW   = PrW + 2;
    localparam int UpW   = UnitW + PdW;
    localparam int RndW  = UpW - ortho_pkg::ProjShift + 1;
    localparam int EcW   = 32;
    localparam int TpW   = InW + XW;
    localparam int TW    = TpW + 2;
    localparam logic [UpW-1:0] RndHalf = UpW'(1) << (ortho_pkg::ProjShift - 1);

    typedef struct packed {
        ortho_pkg::comp_t b_x;
        ortho_pkg::comp_t b_y;
        ortho_pkg::comp_t b_z;
        ortho_pkg::comp_t c_x;
        ortho_pkg::comp_t c_y;
        ortho_pkg::comp_t c_z;
    } n1_side_t;

    typedef struct packed {
        ortho_pkg::unit_t u_x;
        ortho_pkg::unit_t u_y;
        ortho_pkg::unit_t u_z;
        ortho_pkg::comp_t c_x;
        ortho_pkg::comp_t c_y;
        ortho_pkg::comp_t c_z;
        logic             zero;
    } n2_side_t;

    typedef struct packed {
        ortho_pkg::unit_t u_x;
        ortho_pkg::unit_t u_y;
        ortho_pkg::unit_t u_z;
        ortho_pkg::unit_t v_x;
        ortho_pkg::unit_t v_y;
        ortho_pkg::unit_t v_z;
        logic             zero;
        logic             t_neg;
    } n3_side_t;

    typedef struct packed {
        ortho_pkg::unit_t u_x;
        ortho_pkg::unit_t u_y;
        ortho_pkg::unit_t u_z;
        ortho_pkg::unit_t v_x;
        ortho_pkg::unit_t v_y;
        ortho_pkg::unit_t v_z;
        ortho_pkg::unit_t w_x;
        ortho_pkg::unit_t w_y;
        ortho_pkg::unit_t w_z;
        logic             degenerate;
    } frame_t;

    logic adv;
    logic k_v_reg;

    // whole pipeline moves while the skid word is free
    assign adv = !k_v_reg;
    assign in_ch.ready = adv;

    // normalize a
    ortho_pkg::comp_t a_vec [3];
    n1_side_t         n1_in_side;
    logic             n1_v;
    ortho_pkg::unit_t n1_u [3];
    logic             n1_zero;
    n1_side_t         n1_side;

    assign a_vec[0] = in_ch.a_x;
    assign a_vec[1] = in_ch.a_y;
    assign a_vec[2] = in_ch.a_z;
    assign n1_in_side = {in_ch.b_x, in_ch.b_y, in_ch.b_z, in_ch.c_x, in_ch.c_y, in_ch.c_z};

    ortho_norm #(
        .XW (ortho_pkg::NormAW),
        .PW ($bits(n1_side_t))
    ) u_norm_a (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (in_ch.valid),
        .in_x      (a_vec),
        .in_side   (n1_in_side),
        .out_valid (n1_v),
        .out_u     (n1_u),
        .out_zero  (n1_zero),
        .out_side  (n1_side)
    );

    ortho_pkg::comp_t n1_b [3];
    ortho_pkg::comp_t n1_c [3];
    assign n1_b[0] = n1_side.b_x;
    assign n1_b[1] = n1_side.b_y;
    assign n1_b[2] = n1_side.b_z;
    assign n1_c[0] = n1_side.c_x;
    assign n1_c[1] = n1_side.c_y;
    assign n1_c[2] = n1_side.c_z;

    // projection stages: u.b, then u*p, then rounding, then residual
    logic                   p1_v_reg, p2_v_reg, p3_v_reg, p4_v_reg, p5_v_reg;
    logic                   p1_z_reg, p2_z_reg, p3_z_reg, p4_z_reg, p5_z_reg;
    ortho_pkg::unit_t       p1_u_reg [3], p2_u_reg [3], p3_u_reg [3];
    ortho_pkg::unit_t       p4_u_reg [3], p5_u_reg [3];
    ortho_pkg::comp_t       p1_b_reg [3], p2_b_reg [3], p3_b_reg [3], p4_b_reg [3];
    ortho_pkg::comp_t       p1_c_reg [3], p2_c_reg [3], p3_c_reg [3];
    ortho_pkg::comp_t       p4_c_reg [3], p5_c_reg [3];
    logic signed [PrW-1:0]  p1_pr_reg [3];
    logic signed [PdW-1:0]  p2_p_reg;
    logic signed [UpW-1:0]  p3_up_reg [3];
    logic signed [RndW-1:0] p4_r_reg [3];
    logic signed [EW-1:0]   p5_e_reg [3];

    logic signed [PrW-1:0]  p1_pr_next [3];
    logic signed [UpW-1:0]  p3_up_next [3];
    logic signed [RndW-1:0] p4_r_next [3];
    logic signed [EW-1:0]   p5_e_next [3];

    always_comb
    begin
        logic signed [PrW-1:0] ue;
        logic signed [PrW-1:0] be;
        logic signed [UpW-1:0] uw;
        logic signed [UpW-1:0] pw;
        logic [UpW-1:0]        mag;
        logic [UpW-1:0]        rsum;
        logic [RndW-1:0]       m;
        logic signed [EcW-1:0] bs;
        logic signed [EcW-1:0] ed;
        for (int k = 0; k < 3; k++)
        begin
            ue = PrW'(n1_u[k]);
            be = PrW'(n1_b[k]);
            p1_pr_next[k] = ue * be;
            uw = UpW'(p2_u_reg[k]);
            pw = UpW'(p2_p_reg);
            p3_up_next[k] = uw * pw;
            mag = p3_up_reg[k][UpW-1] ? UpW'(-p3_up_reg[k]) : UpW'(p3_up_reg[k]);
            rsum = mag + RndHalf;
            m = RndW'(rsum >> ortho_pkg::ProjShift);
            p4_r_next[k] = p3_up_reg[k][UpW-1] ? -$signed(m) : $signed(m);
            bs = EcW'(p4_b_reg[k]) <<< ortho_pkg::BScale;
            ed = bs - EcW'(p4_r_reg[k]);
            p5_e_next[k] = EW'(ed);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_v_reg <= 1'b0;
            p2_v_reg <= 1'b0;
            p3_v_reg <= 1'b0;
            p4_v_reg <= 1'b0;
            p5_v_reg <= 1'b0;
        end
        else if (adv)
        begin
            p1_v_reg <= n1_v;
            p2_v_reg <= p1_v_reg;
            p3_v_reg <= p2_v_reg;
            p4_v_reg <= p3_v_reg;
            p5_v_reg <= p4_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p1_z_reg <= n1_zero;
            p1_u_reg <= n1_u;
            p1_b_reg <= n1_b;
            p1_c_reg <= n1_c;
            p1_pr_reg <= p1_pr_next;

            p2_z_reg <= p1_z_reg;
            p2_u_reg <= p1_u_reg;
            p2_b_reg <= p1_b_reg;
            p2_c_reg <= p1_c_reg;
            p2_p_reg <= PdW'(p1_pr_reg[0]) + PdW'(p1_pr_reg[1]) + PdW'(p1_pr_reg[2]);

            p3_z_reg <= p2_z_reg;
            p3_u_reg <= p2_u_reg;
            p3_b_reg <= p2_b_reg;
            p3_c_reg <= p2_c_reg;
            p3_up_reg <= p3_up_next;

            p4_z_reg <= p3_z_reg;
            p4_u_reg <= p3_u_reg;
            p4_b_reg <= p3_b_reg;
            p4_c_reg <= p3_c_reg;
            p4_r_reg <= p4_r_next;

            p5_z_reg <= p4_z_reg;
            p5_u_reg <= p4_u_reg;
            p5_c_reg <= p4_c_reg;
            p5_e_reg <= p5_e_next;
        end
    end

    // normalize the residual of b
    n2_side_t         n2_in_side;
    logic             n2_v;
    ortho_pkg::unit_t n2_u [3];
    logic             n2_zero;
    n2_side_t         n2_side;

    assign n2_in_side = {p5_u_reg[0], p5_u_reg[1], p5_u_reg[2],
                         p5_c_reg[0], p5_c_reg[1], p5_c_reg[2], p5_z_reg};

    ortho_norm #(
        .XW (EW),
        .PW ($bits(n2_side_t))
    ) u_norm_e (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (p5_v_reg),
        .in_x      (p5_e_reg),
        .in_side   (n2_in_side),
        .out_valid (n2_v),
        .out_u     (n2_u),
        .out_zero  (n2_zero),
        .out_side  (n2_side)
    );

    ortho_pkg::unit_t n2_uv [3];
    ortho_pkg::comp_t n2_c [3];
    assign n2_uv[0] = n2_side.u_x;
    assign n2_uv[1] = n2_side.u_y;
    assign n2_uv[2] = n2_side.u_z;
    assign n2_c[0] = n2_side.c_x;
    assign n2_c[1] = n2_side.c_y;
    assign n2_c[2] = n2_side.c_z;

    // cross product u x v and orientation products c_i * x_i
    logic                   x1_v_reg, x2_v_reg, x3_v_reg;
    logic                   x1_z_reg, x2_z_reg, x3_z_reg;
    ortho_pkg::unit_t       x1_u_reg [3], x2_u_reg [3], x3_u_reg [3];
    ortho_pkg::unit_t       x1_w_reg [3], x2_w_reg [3], x3_w_reg [3];
    ortho_pkg::comp_t       x1_c_reg [3], x2_c_reg [3];
    logic signed [PrW-1:0]  x1_pr_reg [6];
    logic signed [XW-1:0]   x2_x_reg [3], x3_x_reg [3];
    logic signed [TpW-1:0]  x3_tp_reg [3];

    logic signed [PrW-1:0]  x1_pr_next [6];
    logic signed [TpW-1:0]  x3_tp_next [3];

    always_comb
    begin
        logic signed [PrW-1:0] ua [3];
        logic signed [PrW-1:0] va [3];
        logic signed [TpW-1:0] ce;
        logic signed [TpW-1:0] xe;
        for (int k = 0; k < 3; k++)
        begin
            ua[k] = PrW'(n2_uv[k]);
            va[k] = PrW'(n2_u[k]);
        end
        // pairs for x, y and z components
        x1_pr_next[0] = ua[1] * va[2];
        x1_pr_next[1] = ua[2] * va[1];
        x1_pr_next[2] = ua[2] * va[0];
        x1_pr_next[3] = ua[0] * va[2];
        x1_pr_next[4] = ua[0] * va[1];
        x1_pr_next[5] = ua[1] * va[0];
        for (int k = 0; k < 3; k++)
        begin
            ce = TpW'(x2_c_reg[k]);
            xe = TpW'(x2_x_reg[k]);
            x3_tp_next[k] = ce * xe;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x1_v_reg <= 1'b0;
            x2_v_reg <= 1'b0;
            x3_v_reg <= 1'b0;
        end
        else if (adv)
        begin
            x1_v_reg <= n2_v;
            x2_v_reg <= x1_v_reg;
            x3_v_reg <= x2_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            x1_z_reg <= n2_side.zero | n2_zero;
            x1_u_reg <= n2_uv;
            x1_w_reg <= n2_u;
            x1_c_reg <= n2_c;
            x1_pr_reg <= x1_pr_next;

            x2_z_reg <= x1_z_reg;
            x2_u_reg <= x1_u_reg;
            x2_w_reg <= x1_w_reg;
            x2_c_reg <= x1_c_reg;
            for (int k = 0; k < 3; k++)
                x2_x_reg[k] <= XW'(x1_pr_reg[2*k] - x1_pr_reg[2*k+1]);

            x3_z_reg <= x2_z_reg;
            x3_u_reg <= x2_u_reg;
            x3_w_reg <= x2_w_reg;
            x3_x_reg <= x2_x_reg;
            x3_tp_reg <= x3_tp_next;
        end
    end

    // orientation dot, sign and zero go with the cross product
    logic signed [TW-1:0] t_sum;
    n3_side_t             n3_in_side;
    logic                 n3_v;
    ortho_pkg::unit_t     n3_u [3];
    logic                 n3_zero;
    n3_side_t             n3_side;

    assign t_sum = TW'(x3_tp_reg[0]) + TW'(x3_tp_reg[1]) + TW'(x3_tp_reg[2]);
    assign n3_in_side = {x3_u_reg[0], x3_u_reg[1], x3_u_reg[2],
                         x3_w_reg[0], x3_w_reg[1], x3_w_reg[2],
                         x3_z_reg | (t_sum == '0), t_sum[TW-1]};

    ortho_norm #(
        .XW (XW),
        .PW ($bits(n3_side_t))
    ) u_norm_x (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (x3_v_reg),
        .in_x      (x3_x_reg),
        .in_side   (n3_in_side),
        .out_valid (n3_v),
        .out_u     (n3_u),
        .out_zero  (n3_zero),
        .out_side  (n3_side)
    );

    // assemble the frame, flip w by orientation, clear on degenerate
    frame_t f_frame;
    logic   f_deg;

    assign f_deg = n3_side.zero | n3_zero;

    always_comb
    begin
        f_frame.u_x = n3_side.u_x;
        f_frame.u_y = n3_side.u_y;
        f_frame.u_z = n3_side.u_z;
        f_frame.v_x = n3_side.v_x;
        f_frame.v_y = n3_side.v_y;
        f_frame.v_z = n3_side.v_z;
        f_frame.w_x = n3_side.t_neg ? -n3_u[0] : n3_u[0];
        f_frame.w_y = n3_side.t_neg ? -n3_u[1] : n3_u[1];
        f_frame.w_z = n3_side.t_neg ? -n3_u[2] : n3_u[2];
        f_frame.degenerate = 1'b0;
        if (f_deg)
        begin
            f_frame = '0;
            f_frame.degenerate = 1'b1;
        end
    end

    // output word plus one skid word
    logic   o_v_reg;
    frame_t o_reg;
    frame_t k_reg;
    logic   o_take;

    assign o_take = o_v_reg && out_ch.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            o_v_reg <= 1'b0;
            k_v_reg <= 1'b0;
        end
        else if (k_v_reg)
        begin
            if (o_take)
                k_v_reg <= 1'b0;
        end
        else if (!o_v_reg || o_take)
            o_v_reg <= n3_v;
        else if (n3_v)
            k_v_reg <= 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (k_v_reg)
        begin
            if (o_take)
                o_reg <= k_reg;
        end
        else if (!o_v_reg || o_take)
        begin
            if (n3_v)
                o_reg <= f_frame;
        end
        else if (n3_v)
            k_reg <= f_frame;
    end

    assign out_ch.valid = o_v_reg;
    assign out_ch.u_x = o_reg.u_x;
    assign out_ch.u_y = o_reg.u_y;
    assign out_ch.u_z = o_reg.u_z;
    assign out_ch.v_x = o_reg.v_x;
    assign out_ch.v_y = o_reg.v_y;
    assign out_ch.v_z = o_reg.v_z;
    assign out_ch.w_x = o_reg.w_x;
    assign out_ch.w_y = o_reg.w_y;
    assign out_ch.w_z = o_reg.w_z;
    assign out_ch.degenerate = o_reg.degenerate;

    // checks
    `ORTHO_ASSERT_NOW(a_degen_clear, out_ch.valid && out_ch.degenerate,
        out_ch.u_x == 0 && out_ch.u_y == 0 && out_ch.u_z == 0 && out_ch.v_x == 0 &&
        out_ch.v_y == 0 && out_ch.v_z == 0 && out_ch.w_x == 0 && out_ch.w_y == 0 &&
        out_ch.w_z == 0, "degenerate frame carries nonzero components")
    `ORTHO_ASSERT_NOW(a_skid_behind_out, k_v_reg, o_v_reg,
        "skid word held without an output word")
    `ORTHO_ASSERT_NEXT(a_skid_hold, k_v_reg && !out_ch.ready, k_v_reg,
        "skid word dropped while output stalled")

endmodule

// ----- hw/rtl/ortho_norm.sv -----
`timescale 1ns / 1ps

// pipelined vector normalizer: square, sum, restoring divide, square root, round
module ortho_norm #(
    parameter int XW = ortho_pkg::NormAW,
    parameter int PW = 1
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   adv,
    input  logic                   in_valid,
    input  logic signed [XW-1:0]   in_x [3],
    input  logic [PW-1:0]          in_side,
    output logic                   out_valid,
    output ortho_pkg::unit_t       out_u [3],
    output logic                   out_zero,
    output logic [PW-1:0]          out_side
);

    localparam int MW  = 2 * XW - 1;
    localparam int SW  = MW + 2;
    localparam int QB  = ortho_pkg::QuotW;
    localparam int NDS = QB - 1;
    localparam int NSQ = (QB + 1) / 2;
    localparam int UW  = ortho_pkg::UnitW;
    localparam logic [QB-1:0] RMax = QB'(ortho_pkg::UnitOne);

    // squares
    logic               sq_v_reg;
    logic [MW-1:0]      sq_x2_reg [3];
    logic               sq_neg_reg [3];
    logic [PW-1:0]      sq_side_reg;
    logic [MW-1:0]      sq_x2_next [3];

    always_comb
    begin
        logic [XW-1:0]   mag;
        logic [2*XW-1:0] prod;
        for (int k = 0; k < 3; k++)
        begin
            mag = in_x[k][XW-1] ? XW'(-in_x[k]) : XW'(in_x[k]);
            prod = {{XW{1'b0}}, mag} * {{XW{1'b0}}, mag};
            sq_x2_next[k] = prod[MW-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sq_v_reg <= 1'b0;
        else if (adv)
            sq_v_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int k = 0; k < 3; k++)
            begin
                sq_x2_reg[k] <= sq_x2_next[k];
                sq_neg_reg[k] <= in_x[k][XW-1];
            end
            sq_side_reg <= in_side;
        end
    end

    // sum of squares
    logic               su_v_reg;
    logic [SW-1:0]      su_s_reg;
    logic [MW-1:0]      su_x2_reg [3];
    logic               su_neg_reg [3];
    logic [PW-1:0]      su_side_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            su_v_reg <= 1'b0;
        else if (adv)
            su_v_reg <= sq_v_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            su_s_reg <= {2'b00, sq_x2_reg[0]} + {2'b00, sq_x2_reg[1]}
                      + {2'b00, sq_x2_reg[2]};
            su_x2_reg <= sq_x2_reg;
            su_neg_reg <= sq_neg_reg;
            su_side_reg <= sq_side_reg;
        end
    end

    // divider pipeline, entry 0 is the leading integer step
    logic               d_v_reg    [NDS+1];
    logic [SW-1:0]      d_s_reg    [NDS+1];
    logic [SW-1:0]      d_rem_reg  [NDS+1][3];
    logic [QB-1:0]      d_q_reg    [NDS+1][3];
    logic               d_neg_reg  [NDS+1][3];
    logic               d_zero_reg [NDS+1];
    logic [PW-1:0]      d_side_reg [NDS+1];

    logic [SW-1:0]      d0_rem_next [3];
    logic [QB-1:0]      d0_q_next   [3];

    // x^2 at or above s gives a leading one; the rest is clipped below s
    always_comb
    begin
        logic [SW-1:0] x2e;
        logic          ge1;
        logic          ge2;
        for (int k = 0; k < 3; k++)
        begin
            x2e = {2'b00, su_x2_reg[k]};
            ge1 = (x2e >= su_s_reg);
            ge2 = ({1'b0, x2e} >= {su_s_reg, 1'b0});
            if (ge2)
                d0_rem_next[k] = su_s_reg - SW'(1);
            else if (ge1)
                d0_rem_next[k] = x2e - su_s_reg;
            else
                d0_rem_next[k] = x2e;
            d0_q_next[k] = QB'(ge1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            d_v_reg[0] <= 1'b0;
        else if (adv)
            d_v_reg[0] <= su_v_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            d_s_reg[0] <= su_s_reg;
            d_rem_reg[0] <= d0_rem_next;
            d_q_reg[0] <= d0_q_next;
            d_neg_reg[0] <= su_neg_reg;
            d_zero_reg[0] <= (su_s_reg == '0);
            d_side_reg[0] <= su_side_reg;
        end
    end

    for (genvar j = 1; j <= NDS; j++)
    begin : g_div
        logic [SW-1:0] rem_next [3];
        logic [QB-1:0] q_next   [3];

        // one quotient bit per stage
        always_comb
        begin
            logic [SW:0] rs;
            logic [SW:0] diff;
            logic        ge;
            for (int k = 0; k < 3; k++)
            begin
                rs = {d_rem_reg[j-1][k], 1'b0};
                diff = rs - {1'b0, d_s_reg[j-1]};
                ge = (rs >= {1'b0, d_s_reg[j-1]});
                rem_next[k] = ge ? diff[SW-1:0] : rs[SW-1:0];
                q_next[k] = {d_q_reg[j-1][k][QB-2:0], ge};
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                d_v_reg[j] <= 1'b0;
            else if (adv)
                d_v_reg[j] <= d_v_reg[j-1];
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                d_s_reg[j] <= d_s_reg[j-1];
                d_rem_reg[j] <= rem_next;
                d_q_reg[j] <= q_next;
                d_neg_reg[j] <= d_neg_reg[j-1];
                d_zero_reg[j] <= d_zero_reg[j-1];
                d_side_reg[j] <= d_side_reg[j-1];
            end
        end
    end

    // square root pipeline, two radicand bits per stage
    logic               st_v    [NSQ];
    logic [QB-1:0]      st_n    [NSQ][3];
    logic [QB-1:0]      st_res  [NSQ][3];
    logic               st_neg  [NSQ][3];
    logic               st_zero [NSQ];
    logic [PW-1:0]      st_side [NSQ];

    logic               rt_v_reg    [NSQ];
    logic [QB-1:0]      rt_n_reg    [NSQ][3];
    logic [QB-1:0]      rt_res_reg  [NSQ][3];
    logic               rt_neg_reg  [NSQ][3];
    logic               rt_zero_reg [NSQ];
    logic [PW-1:0]      rt_side_reg [NSQ];

    for (genvar j = 0; j < NSQ; j++)
    begin : g_sqrt
        localparam logic [QB-1:0] SqBit = QB'(1) << (QB - 1 - 2 * j);
        logic [QB-1:0] n_next   [3];
        logic [QB-1:0] res_next [3];

        if (j == 0)
        begin : g_first
            assign st_v[j] = d_v_reg[NDS];
            assign st_n[j] = d_q_reg[NDS];
            assign st_res[j] = '{default: '0};
            assign st_neg[j] = d_neg_reg[NDS];
            assign st_zero[j] = d_zero_reg[NDS];
            assign st_side[j] = d_side_reg[NDS];
        end
        else
        begin : g_rest
            assign st_v[j] = rt_v_reg[j-1];
            assign st_n[j] = rt_n_reg[j-1];
            assign st_res[j] = rt_res_reg[j-1];
            assign st_neg[j] = rt_neg_reg[j-1];
            assign st_zero[j] = rt_zero_reg[j-1];
            assign st_side[j] = rt_side_reg[j-1];
        end

        always_comb
        begin
            logic [QB:0] trial;
            for (int k = 0; k < 3; k++)
            begin
                trial = {1'b0, st_res[j][k]} + {1'b0, SqBit};
                if ({1'b0, st_n[j][k]} >= trial)
                begin
                    n_next[k] = st_n[j][k] - trial[QB-1:0];
                    res_next[k] = (st_res[j][k] >> 1) + SqBit;
                end
                else
                begin
                    n_next[k] = st_n[j][k];
                    res_next[k] = st_res[j][k] >> 1;
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                rt_v_reg[j] <= 1'b0;
            else if (adv)
                rt_v_reg[j] <= st_v[j];
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                rt_n_reg[j] <= n_next;
                rt_res_reg[j] <= res_next;
                rt_neg_reg[j] <= st_neg[j];
                rt_zero_reg[j] <= st_zero[j];
                rt_side_reg[j] <= st_side[j];
            end
        end
    end

    // round the root to Q1.14 and restore the sign
    logic                f_v_reg;
    ortho_pkg::unit_t    f_u_reg [3];
    logic                f_zero_reg;
    logic [PW-1:0]       f_side_reg;
    ortho_pkg::unit_t    f_u_next [3];

    always_comb
    begin
        logic [QB:0]   rp1;
        logic [QB-1:0] rr;
        logic [UW-1:0] mag;
        for (int k = 0; k < 3; k++)
        begin
            rp1 = {1'b0, rt_res_reg[NSQ-1][k]} + (QB+1)'(1);
            rr = rp1[QB:1];
            if (rr > RMax)
                rr = RMax;
            mag = rr[UW-1:0];
            f_u_next[k] = rt_neg_reg[NSQ-1][k] ? -$signed(mag) : $signed(mag);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            f_v_reg <= 1'b0;
        else if (adv)
            f_v_reg <= rt_v_reg[NSQ-1];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            f_u_reg <= f_u_next;
            f_zero_reg <= rt_zero_reg[NSQ-1];
            f_side_reg <= rt_side_reg[NSQ-1];
        end
    end

    assign out_valid = f_v_reg;
    assign out_u = f_u_reg;
    assign out_zero = f_zero_reg;
    assign out_side = f_side_reg;

endmodule
